// ===== rtl/lfkp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package lfkp_pkg;
    localparam int ALPHABET_SIZE_DEF = 26;
    localparam int COUNT_WIDTH_DEF   = 20;
    localparam int WEIGHT_WIDTH_DEF  = 16;
    localparam int LETTERS           = 26;
    localparam int MAX_RESULTS       = 26;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_CHAR   = 2'd1,
        OP_FINISH = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_RANK,
        S_EMIT,
        S_CLEAR
    } t_state;

    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [6:0] ASCII_A      = 7'h41;
endpackage
`default_nettype wire

// ===== rtl/lfkp_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none
module lfkp_mem #(
    parameter int DEPTH = 26,
    parameter int WIDTH = 16
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire [$clog2(DEPTH)-1:0]  i_waddr,
    input  wire [WIDTH-1:0]          i_wdata,
    input  wire [$clog2(DEPTH)-1:0]  i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/letter_frequency_key_proposer.sv =====
// Channel | Dir | tdata (low bit up)                                      | tuser
// s_axis  | in  | letter_index[4:0] ref_weight[20:5] text_char[28:21] pad | operation[1:0]
// m_axis  | out | plain_index[4:0] cipher_letter[11:5] pad               | -   ; tlast=last_entry
// Load transactions write the weight memory. Text transactions, taken only while idle, do one
// read-modify-write per cycle on the count memory, with forwarding from the write stage when
// the same letter repeats. Finish: memory reads of all letters, then rank by pairwise compare
// (one letter per cycle), then min(N, MAX_RESULTS) results with N = ALPHABET_SIZE, then count
// clear. The sink may stall emission at any cycle.
// Reset clears weights and counts with a sweep over all letters during which s_axis_tready is low.
`timescale 1ns / 1ps
`default_nettype none
module letter_frequency_key_proposer #(
    parameter int ALPHABET_SIZE = lfkp_pkg::ALPHABET_SIZE_DEF,
    parameter int COUNT_WIDTH   = lfkp_pkg::COUNT_WIDTH_DEF,
    parameter int WEIGHT_WIDTH  = lfkp_pkg::WEIGHT_WIDTH_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [31:0] s_axis_tdata,  // letter_index, ref_weight, text_char
    input  wire  [1:0]  s_axis_tuser,  // operation
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [15:0] m_axis_tdata,  // plain_index, cipher_letter
    output logic        m_axis_tlast
);
    localparam int AW = $clog2(ALPHABET_SIZE);
    localparam int RW = $clog2(ALPHABET_SIZE + 1);
    localparam int NOUT = (ALPHABET_SIZE < lfkp_pkg::MAX_RESULTS) ? ALPHABET_SIZE
                                                                  : lfkp_pkg::MAX_RESULTS;
    localparam logic [COUNT_WIDTH-1:0] CMAX = '1;

    lfkp_pkg::t_state r_state, n_state;
    logic [RW-1:0] r_i, n_i;
    logic          r_rd;

    assign s_axis_tready = (r_state == lfkp_pkg::S_IDLE);

    wire        acc    = s_axis_tvalid && s_axis_tready;
    wire [1:0]  op     = s_axis_tuser;
    wire [4:0]  lidx   = s_axis_tdata[4:0];
    wire [15:0] wt     = s_axis_tdata[20:5];
    wire [7:0]  ch     = s_axis_tdata[28:21];

    logic       is_up, is_lo, is_let;
    logic [4:0] cidx;
    always_comb begin
        is_up  = ch >= lfkp_pkg::CHAR_UPPER_A && ch <= lfkp_pkg::CHAR_UPPER_Z;
        is_lo  = ch >= lfkp_pkg::CHAR_LOWER_A && ch <= lfkp_pkg::CHAR_LOWER_Z;
        cidx   = is_up ? 5'(ch - lfkp_pkg::CHAR_UPPER_A) : 5'(ch - lfkp_pkg::CHAR_LOWER_A);
        is_let = (is_up || is_lo) && (32'(cidx) < ALPHABET_SIZE);
    end

    // count pipeline: read in cycle of acceptance, write next cycle
    logic                   r_inc_v;
    logic [AW-1:0]          r_inc_a;
    logic                   c_we, w_we;
    logic [AW-1:0]          c_wa, c_ra, w_wa, w_ra;
    logic [COUNT_WIDTH-1:0] c_wd, c_rd, c_cur;
    logic [WEIGHT_WIDTH-1:0] w_wd, w_rd;
    logic                   r_fwd_v;
    logic [AW-1:0]          r_fwd_a;
    logic [COUNT_WIDTH-1:0] r_fwd_d;

    lfkp_mem #(.DEPTH(ALPHABET_SIZE), .WIDTH(COUNT_WIDTH)) u_cnt (
        .i_clk(i_clk), .i_we(c_we), .i_waddr(c_wa), .i_wdata(c_wd),
        .i_raddr(c_ra), .o_rdata(c_rd));
    lfkp_mem #(.DEPTH(ALPHABET_SIZE), .WIDTH(WEIGHT_WIDTH)) u_wgt (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_wa), .i_wdata(w_wd),
        .i_raddr(w_ra), .o_rdata(w_rd));

    assign c_cur = (r_fwd_v && r_fwd_a == r_inc_a) ? r_fwd_d : c_rd;

    // ranking copies: key registers per letter, rank counters
    logic [COUNT_WIDTH-1:0]  r_ck [ALPHABET_SIZE];
    logic [WEIGHT_WIDTH-1:0] r_wk [ALPHABET_SIZE];
    logic [AW-1:0]           r_rref [ALPHABET_SIZE];
    logic [AW-1:0]           r_rtxt [ALPHABET_SIZE];
    logic [AW-1:0]           r_ref_at, r_txt_at;
    logic [AW-1:0]           r_j;

    always_comb begin
        n_state = r_state;
        n_i = r_i;
        c_we = 1'b0; c_wa = r_inc_a; c_wd = (c_cur == CMAX) ? c_cur : c_cur + 1'b1;
        c_ra = AW'(cidx);
        w_we = 1'b0; w_wa = AW'(lidx); w_wd = WEIGHT_WIDTH'(wt);
        w_ra = AW'(r_i);
        if (r_inc_v) c_we = 1'b1;
        unique case (r_state)
            lfkp_pkg::S_IDLE: begin
                if (acc && op == lfkp_pkg::OP_LOAD && 32'(lidx) < ALPHABET_SIZE) w_we = 1'b1;
                if (acc && op == lfkp_pkg::OP_FINISH) begin
                    n_state = lfkp_pkg::S_READ;
                    n_i = '0;
                end
            end
            lfkp_pkg::S_READ: begin
                c_ra = AW'(r_i);
                if (32'(r_i) == ALPHABET_SIZE) begin
                    n_state = lfkp_pkg::S_RANK;
                    n_i = '0;
                end else n_i = r_i + 1'b1;
            end
            lfkp_pkg::S_RANK: begin
                if (32'(r_i) == ALPHABET_SIZE - 1) begin
                    n_state = lfkp_pkg::S_EMIT;
                    n_i = '0;
                end else n_i = r_i + 1'b1;
            end
            lfkp_pkg::S_EMIT: begin
                if (m_axis_tvalid && m_axis_tready && m_axis_tlast) begin
                    n_state = lfkp_pkg::S_CLEAR;
                    n_i = '0;
                end
            end
            lfkp_pkg::S_CLEAR: begin
                c_we = 1'b1; c_wa = AW'(r_i); c_wd = '0;
                w_we = !r_rd; w_wa = AW'(r_i); w_wd = '0;
                if (32'(r_i) == ALPHABET_SIZE - 1) begin
                    n_state = lfkp_pkg::S_IDLE;
                    n_i = '0;
                end else n_i = r_i + 1'b1;
            end
            default: n_state = lfkp_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lfkp_pkg::S_CLEAR;
            r_i     <= '0;
            r_rd    <= 1'b0;
            r_inc_v <= 1'b0;
            r_fwd_v <= 1'b0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            if (r_state == lfkp_pkg::S_CLEAR && n_state == lfkp_pkg::S_IDLE) r_rd <= 1'b1;
            r_inc_v <= acc && op == lfkp_pkg::OP_CHAR && is_let;
            r_fwd_v <= r_inc_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_inc_a <= AW'(cidx);
        r_fwd_a <= r_inc_a;
        r_fwd_d <= c_wd;
    end

    // capture keys: read at r_i, data valid when r_i-1 address read
    always_ff @(posedge i_clk) begin
        if (r_state == lfkp_pkg::S_READ && r_i != '0) begin
            r_ck[AW'(r_i - 1'b1)] <= c_rd;
            r_wk[AW'(r_i - 1'b1)] <= w_rd;
        end
    end

    // rank of letter j: keys strictly smaller, or equal with smaller index
    logic [ALPHABET_SIZE-1:0] lt_ref, lt_txt;
    logic [AW-1:0]            rk_ref, rk_txt;
    always_comb begin
        for (int k = 0; k < ALPHABET_SIZE; k++) begin
            lt_ref[k] = r_wk[k] < r_wk[AW'(r_i)] ||
                        (r_wk[k] == r_wk[AW'(r_i)] && k < 32'(r_i));
            lt_txt[k] = r_ck[k] < r_ck[AW'(r_i)] ||
                        (r_ck[k] == r_ck[AW'(r_i)] && k < 32'(r_i));
        end
        rk_ref = AW'($countones(lt_ref));
        rk_txt = AW'($countones(lt_txt));
    end

    always_ff @(posedge i_clk) begin
        if (r_state == lfkp_pkg::S_RANK) begin
            r_rref[rk_ref] <= AW'(r_i);
            r_rtxt[rk_txt] <= AW'(r_i);
        end
    end

    // emit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tvalid <= 1'b0;
            r_j <= '0;
        end else if (r_state == lfkp_pkg::S_EMIT) begin
            if (!m_axis_tvalid || m_axis_tready) begin
                if (m_axis_tvalid && m_axis_tlast) begin
                    m_axis_tvalid <= 1'b0;
                    r_j <= '0;
                end else begin
                    m_axis_tvalid <= 1'b1;
                    r_j <= r_j + 1'b1;
                end
            end
        end else begin
            m_axis_tvalid <= 1'b0;
            r_j <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == lfkp_pkg::S_EMIT &&
            (!m_axis_tvalid || (m_axis_tready && !m_axis_tlast))) begin
            r_ref_at     <= r_rref[r_j];
            r_txt_at     <= r_rtxt[r_j];
            m_axis_tlast <= (32'(r_j) == NOUT - 1);
        end
    end

    assign m_axis_tdata = {4'd0, 7'(lfkp_pkg::ASCII_A + 7'(r_txt_at)), 5'(r_ref_at)};

`ifndef SYNTH
    a_no_out_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == lfkp_pkg::S_IDLE |-> !m_axis_tvalid) else $error("output outside emit");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready) else $error("input taken during emit");
    a_clear_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tlast |=> r_state == lfkp_pkg::S_CLEAR)
        else $error("clear skipped");
`endif
endmodule
`default_nettype wire
